// ----- rtl/pwl_pkg.sv -----
// Shared package of the piecewise-linear profile lookup.
// It holds the field widths, the request codes, the table entry type and the divider structs.
// It depends on nothing else.
package pwl_pkg;

   localparam int TIME_W             = 32;
   localparam int ACCEL_W            = 16;
   localparam int DUR_W              = 16;
   localparam int IDX_W              = 4;
   localparam int COUNT_W            = 5;
   localparam int DIFF_W             = TIME_W + 1;
   localparam int VDIFF_W            = ACCEL_W + 1;
   localparam int PROD_W             = DIFF_W + VDIFF_W;
   localparam int MAG_W              = PROD_W - 1;
   localparam int DEN_W              = TIME_W;
   localparam int SUM_W              = MAG_W + 2;
   localparam int REQ_DATA_W         = 104;
   localparam int RSP_DATA_W         = 32;
   localparam int MAX_POINTS_DEFAULT = 16;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic        [DUR_W-1:0]   duration;
      logic signed [ACCEL_W-1:0] accel;
      logic signed [TIME_W-1:0]  time_us;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/pwl_table_ram.sv -----
// Point table storage of the profile lookup: one write port and one read port.
// The read data is registered, so it appears in the cycle after the address.
// It depends on pwl_pkg for the entry type.
module pwl_table_ram #(
   parameter int DEPTH  = pwl_pkg::MAX_POINTS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pwl_pkg::entry_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output pwl_pkg::entry_type  rd_data
);
   import pwl_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pwl_divider.sv -----
// Restoring unsigned divider that retires one quotient bit per cycle.
// The quotient holds its value and done stays high until the next start.
// It depends on pwl_pkg for the widths and the request and response structs.
module pwl_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pwl_pkg::div_req_type  div_req,
   output pwl_pkg::div_rsp_type  div_rsp
);
   import pwl_pkg::*;

   localparam int CNT_W = $clog2(MAG_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] div_ff, div_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/pwl_seq.sv -----
// Request sequencer of the profile lookup: table reads, search, interpolation setup,
// result assembly and the result register.
// It depends on pwl_pkg and drives the table memory and the two dividers.
module pwl_seq #(
   parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEFAULT,
   parameter int ADDR_W     = $clog2(MAX_POINTS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pwl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pwl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [pwl_pkg::COUNT_W-1:0]    point_count,
   output logic                           mem_wr_en,
   output logic [ADDR_W-1:0]              mem_wr_addr,
   output pwl_pkg::entry_type             mem_wr_data,
   output logic [ADDR_W-1:0]              mem_rd_addr,
   input  pwl_pkg::entry_type             mem_rd_data,
   output pwl_pkg::div_req_type           div_accel_req,
   input  pwl_pkg::div_rsp_type           div_accel_rsp,
   output pwl_pkg::div_req_type           div_dur_req,
   input  pwl_pkg::div_rsp_type           div_dur_rsp
);
   import pwl_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CHK_FIRST = 4'd1;
   localparam logic [3:0] ST_CHK_LAST  = 4'd2;
   localparam logic [3:0] ST_SCAN      = 4'd3;
   localparam logic [3:0] ST_DIFF      = 4'd4;
   localparam logic [3:0] ST_MUL       = 4'd5;
   localparam logic [3:0] ST_START     = 4'd6;
   localparam logic [3:0] ST_DIV       = 4'd7;
   localparam logic [3:0] ST_COMBINE   = 4'd8;
   localparam logic [3:0] ST_OUT       = 4'd9;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [COUNT_W-1:0] i);
      logic [ADDR_W+COUNT_W-1:0] w;
      w = {{ADDR_W{1'b0}}, i};
      return w[ADDR_W-1:0];
   endfunction

   logic [3:0]                state_ff, state_in;
   logic signed [TIME_W-1:0]  q_ff, q_in;
   logic [COUNT_W-1:0]        n_ff, n_in;
   logic [COUNT_W-1:0]        idx_ff, idx_in;
   entry_type                 prev_ff, prev_in;
   entry_type                 left_ff, left_in;
   entry_type                 right_ff, right_in;
   logic signed [DIFF_W-1:0]  den_ff, den_in;
   logic signed [DIFF_W-1:0]  dq_ff, dq_in;
   logic signed [VDIFF_W-1:0] da_ff, da_in;
   logic signed [VDIFF_W-1:0] dd_ff, dd_in;
   logic                      den_zero_ff, den_zero_in;
   logic signed [PROD_W-1:0]  pa_ff, pa_in;
   logic signed [PROD_W-1:0]  pd_ff, pd_in;
   logic [ACCEL_W-1:0]        res_accel_ff, res_accel_in;
   logic [DUR_W-1:0]          res_dur_ff, res_dur_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic                      req_cmd;
   logic [IDX_W-1:0]          req_idx;
   logic [ADDR_W+IDX_W-1:0]   req_idx_wide;
   logic signed [TIME_W-1:0]  req_query;
   logic [COUNT_W-1:0]        n_clip;
   logic                      hit;
   logic [PROD_W-1:0]         abs_pa;
   logic [PROD_W-1:0]         abs_pd;
   logic [DIFF_W-1:0]         abs_den;
   logic                      sign_a;
   logic                      sign_d;
   logic signed [SUM_W-1:0]   qa;
   logic signed [SUM_W-1:0]   qd;
   logic signed [SUM_W-1:0]   sum_a;
   logic signed [SUM_W-1:0]   sum_d;
   logic                      out_free;

   assign req_cmd      = req_tuser;
   assign req_idx      = req_tdata[3:0];
   assign req_query    = $signed(req_tdata[99:68]);
   assign req_idx_wide = {{ADDR_W{1'b0}}, req_idx};
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   assign mem_wr_en            = req_fire && (req_cmd == CMD_LOAD)
                                 && (32'(req_idx) < 32'(MAX_POINTS));
   assign mem_wr_addr          = req_idx_wide[ADDR_W-1:0];
   assign mem_wr_data.time_us  = $signed(req_tdata[35:4]);
   assign mem_wr_data.accel    = $signed(req_tdata[51:36]);
   assign mem_wr_data.duration = req_tdata[67:52];

   assign n_clip = (32'(point_count) > 32'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
   assign hit    = ($signed(mem_rd_data.time_us) >= q_ff) || (idx_ff == n_ff - 1'b1);

   assign abs_pa  = pa_ff[PROD_W-1] ? PROD_W'(-pa_ff) : PROD_W'(pa_ff);
   assign abs_pd  = pd_ff[PROD_W-1] ? PROD_W'(-pd_ff) : PROD_W'(pd_ff);
   assign abs_den = den_ff[DIFF_W-1] ? DIFF_W'(-den_ff) : DIFF_W'(den_ff);
   assign sign_a  = pa_ff[PROD_W-1] ^ den_ff[DIFF_W-1];
   assign sign_d  = pd_ff[PROD_W-1] ^ den_ff[DIFF_W-1];

   assign div_accel_req.start    = (state_ff == ST_START);
   assign div_accel_req.dividend = abs_pa[MAG_W-1:0];
   assign div_accel_req.divisor  = abs_den[DEN_W-1:0];
   assign div_dur_req.start      = (state_ff == ST_START);
   assign div_dur_req.dividend   = abs_pd[MAG_W-1:0];
   assign div_dur_req.divisor    = abs_den[DEN_W-1:0];

   always_comb begin
      qa = $signed({{(SUM_W-MAG_W){1'b0}}, div_accel_rsp.quotient});
      qd = $signed({{(SUM_W-MAG_W){1'b0}}, div_dur_rsp.quotient});
      if (sign_a) begin
         qa = -qa;
      end
      if (sign_d) begin
         qd = -qd;
      end
      sum_a = $signed({{(SUM_W-ACCEL_W){left_ff.accel[ACCEL_W-1]}}, left_ff.accel}) + qa;
      sum_d = $signed({{(SUM_W-DUR_W){1'b0}}, left_ff.duration}) + qd;
   end

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      den_in       = den_ff;
      dq_in        = dq_ff;
      da_in        = da_ff;
      dd_in        = dd_ff;
      den_zero_in  = den_zero_ff;
      pa_in        = pa_ff;
      pd_in        = pd_ff;
      res_accel_in = res_accel_ff;
      res_dur_in   = res_dur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_rd_addr  = to_addr(idx_ff + 1'b1);

      unique case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = '0;
            if (req_fire && (req_cmd == CMD_QUERY)) begin
               q_in = req_query;
               n_in = n_clip;
               if (n_clip < COUNT_W'(2)) begin
                  res_accel_in = '0;
                  res_dur_in   = '0;
                  state_in     = ST_OUT;
               end else begin
                  state_in = ST_CHK_FIRST;
               end
            end
         end
         ST_CHK_FIRST: begin
            prev_in     = mem_rd_data;
            mem_rd_addr = to_addr(n_ff - 1'b1);
            if (q_ff <= $signed(mem_rd_data.time_us)) begin
               res_accel_in = mem_rd_data.accel;
               res_dur_in   = mem_rd_data.duration;
               state_in     = ST_OUT;
            end else begin
               state_in = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            mem_rd_addr = to_addr(COUNT_W'(1));
            idx_in      = COUNT_W'(1);
            if (q_ff >= $signed(mem_rd_data.time_us)) begin
               res_accel_in = mem_rd_data.accel;
               res_dur_in   = mem_rd_data.duration;
               state_in     = ST_OUT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               left_in  = prev_ff;
               right_in = mem_rd_data;
               state_in = ST_DIFF;
            end else begin
               prev_in = mem_rd_data;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_DIFF: begin
            den_in      = {right_ff.time_us[TIME_W-1], right_ff.time_us}
                          - {left_ff.time_us[TIME_W-1], left_ff.time_us};
            dq_in       = {q_ff[TIME_W-1], q_ff}
                          - {left_ff.time_us[TIME_W-1], left_ff.time_us};
            da_in       = {right_ff.accel[ACCEL_W-1], right_ff.accel}
                          - {left_ff.accel[ACCEL_W-1], left_ff.accel};
            dd_in       = {1'b0, right_ff.duration} - {1'b0, left_ff.duration};
            den_zero_in = (right_ff.time_us == left_ff.time_us);
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            pa_in    = da_ff * dq_ff;
            pd_in    = dd_ff * dq_ff;
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_accel_rsp.done && div_dur_rsp.done) begin
               state_in = ST_COMBINE;
            end
         end
         ST_COMBINE: begin
            if (den_zero_ff) begin
               res_accel_in = left_ff.accel;
               res_dur_in   = left_ff.duration;
            end else begin
               if ((&sum_a[SUM_W-1:ACCEL_W-1]) || !(|sum_a[SUM_W-1:ACCEL_W-1])) begin
                  res_accel_in = sum_a[ACCEL_W-1:0];
               end else if (sum_a[SUM_W-1]) begin
                  res_accel_in = {1'b1, {(ACCEL_W-1){1'b0}}};
               end else begin
                  res_accel_in = {1'b0, {(ACCEL_W-1){1'b1}}};
               end
               if (sum_d[SUM_W-1]) begin
                  res_dur_in = '0;
               end else if (|sum_d[SUM_W-2:DUR_W]) begin
                  res_dur_in = '1;
               end else begin
                  res_dur_in = sum_d[DUR_W-1:0];
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_dur_ff, res_accel_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff         <= q_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      den_ff       <= den_in;
      dq_ff        <= dq_in;
      da_ff        <= da_in;
      dd_ff        <= dd_in;
      den_zero_ff  <= den_zero_in;
      pa_ff        <= pa_in;
      pd_ff        <= pd_in;
      res_accel_ff <= res_accel_in;
      res_dur_ff   <= res_dur_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/piecewise_linear_profile_lookup_top.sv -----
// Top level of the piecewise-linear profile lookup: point count register, point table,
// sequencer and the two dividers. It depends on pwl_pkg and the other rtl/pwl_ modules.
//
// A load request (tuser low) writes one point into the table. A query request (tuser high)
// returns one response with the acceleration and the duration at the query time, clamped
// to the end points or linearly interpolated between neighbors. With fewer than two valid
// points the response is zero; a query at or before the first point returns that point and
// one at or after the last point returns the last point. For an interpolated answer the
// table is searched one entry per cycle through its single read port up to the first point
// not earlier than the query, and the two serial dividers then retire one quotient bit per
// cycle. The sequencer handles one request at a time, and a finished response waits in its
// own register while the next request is accepted. The table has no reset; only points
// written by loads may be used.
module piecewise_linear_profile_lookup_top #(
   parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // entry_index, entry_time, entry_accel, entry_duration, query_time, zero fill
   input  logic [pwl_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // accel_at_time, duration_at_time
   output logic [pwl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [pwl_pkg::COUNT_W-1:0]    csr_wr_data
);
   import pwl_pkg::*;

   localparam int ADDR_W = $clog2(MAX_POINTS);

   logic [COUNT_W-1:0] point_count_ff, point_count_in;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   entry_type          mem_wr_data;
   logic [ADDR_W-1:0]  mem_rd_addr;
   entry_type          mem_rd_data;
   div_req_type        div_accel_req;
   div_rsp_type        div_accel_rsp;
   div_req_type        div_dur_req;
   div_rsp_type        div_dur_rsp;

   assign point_count_in = csr_wr_en ? csr_wr_data : point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   pwl_table_ram #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pwl_divider u_div_accel (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_accel_req),
      .div_rsp (div_accel_rsp)
   );

   pwl_divider u_div_dur (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_dur_req),
      .div_rsp (div_dur_rsp)
   );

   pwl_seq #(
      .MAX_POINTS (MAX_POINTS),
      .ADDR_W     (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .point_count   (point_count_ff),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .div_accel_req (div_accel_req),
      .div_accel_rsp (div_accel_rsp),
      .div_dur_req   (div_dur_req),
      .div_dur_rsp   (div_dur_rsp)
   );

endmodule

// ----- tb/pwl_lookup_checker.sv -----
`timescale 1ns / 1ps
// Checker for the piecewise-linear profile lookup: watches the request, response and CSR ports,
// keeps its own copy of the point table and count, and predicts every query answer.
// It depends on pwl_pkg for widths and request codes.
module pwl_lookup_checker
   import pwl_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data,
   output int                    error_count,
   output int                    outstanding,
   output int                    answers_checked
);

   localparam int TIME_LSB  = IDX_W;
   localparam int ACCEL_LSB = TIME_LSB + TIME_W;
   localparam int DUR_LSB   = ACCEL_LSB + ACCEL_W;
   localparam int QUERY_LSB = DUR_LSB + DUR_W;

   logic signed [TIME_W-1:0]  tbl_time[MAX_POINTS];
   logic signed [ACCEL_W-1:0] tbl_accel[MAX_POINTS];
   logic        [DUR_W-1:0]   tbl_dur[MAX_POINTS];
   logic        [COUNT_W-1:0] point_count;
   logic [RSP_DATA_W-1:0]     expected_answers[$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic longint blend(input longint v0, input longint t0, input longint v1,
                                    input longint t1, input longint q);
      longint span;
      span = t1 - t0;
      if (span == 0) begin
         return v0;
      end
      return v0 + ((v1 - v0) * (q - t0)) / span;
   endfunction

   function automatic logic [RSP_DATA_W-1:0] profile_at(input logic signed [TIME_W-1:0] q);
      int     n;
      int     found;
      int     left;
      int     right;
      longint qv;
      longint a;
      longint d;
      qv = longint'(q);
      n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
      if (n < 2) begin
         a = 0;
         d = 0;
      end else if (qv <= longint'(tbl_time[0])) begin
         a = longint'(tbl_accel[0]);
         d = longint'(tbl_dur[0]);
      end else if (qv >= longint'(tbl_time[n-1])) begin
         a = longint'(tbl_accel[n-1]);
         d = longint'(tbl_dur[n-1]);
      end else begin
         found = n;
         for (int i = 0; i < n; i++) begin
            if (longint'(tbl_time[i]) >= qv) begin
               found = i;
               break;
            end
         end
         if (found == 0) begin
            left  = 0;
            right = 1;
         end else if (found == n) begin
            left  = n - 1;
            right = n - 2;
         end else begin
            left  = found - 1;
            right = found;
         end
         a = blend(longint'(tbl_accel[left]), longint'(tbl_time[left]),
                   longint'(tbl_accel[right]), longint'(tbl_time[right]), qv);
         d = blend(longint'(tbl_dur[left]), longint'(tbl_time[left]), longint'(tbl_dur[right]),
                   longint'(tbl_time[right]), qv);
         if (a < -32768) a = -32768;
         if (a > 32767) a = 32767;
         if (d < 0) d = 0;
         if (d > 65535) d = 65535;
      end
      return {d[DUR_W-1:0], a[ACCEL_W-1:0]};
   endfunction

   always @(posedge clock) begin : monitor
      logic [RSP_DATA_W-1:0] want;
      int                    slot;
      if (reset) begin
         point_count = '0;
         expected_answers.delete();
         outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("response %h with no query waiting", rsp_tdata));
            end else begin
               want = expected_answers.pop_front();
               answers_checked++;
               if (rsp_tdata[ACCEL_W-1:0] !== want[ACCEL_W-1:0]) begin
                  report_mismatch($sformatf("accel_at_time %h, expected %h",
                                            rsp_tdata[ACCEL_W-1:0], want[ACCEL_W-1:0]));
               end
               if (rsp_tdata[RSP_DATA_W-1:ACCEL_W] !== want[RSP_DATA_W-1:ACCEL_W]) begin
                  report_mismatch($sformatf("duration_at_time %h, expected %h",
                                            rsp_tdata[RSP_DATA_W-1:ACCEL_W],
                                            want[RSP_DATA_W-1:ACCEL_W]));
               end
            end
         end
         if (csr_wr_en) begin
            point_count = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_LOAD) begin
               slot = int'(req_tdata[IDX_W-1:0]);
               if (slot < MAX_POINTS) begin
                  tbl_time[slot]  = req_tdata[TIME_LSB +: TIME_W];
                  tbl_accel[slot] = req_tdata[ACCEL_LSB +: ACCEL_W];
                  tbl_dur[slot]   = req_tdata[DUR_LSB +: DUR_W];
               end
            end else begin
               expected_answers.push_back(profile_at(req_tdata[QUERY_LSB +: TIME_W]));
            end
         end
         outstanding = expected_answers.size();
      end
   end

endmodule

// ----- tb/piecewise_linear_profile_lookup_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the piecewise-linear profile lookup: clock, reset, point loads, queries,
// point-count settings and handshake pressure, with the verdict taken from pwl_lookup_checker.
// It depends on pwl_pkg, the lookup RTL and the checker.
module piecewise_linear_profile_lookup_top_tb;
   import pwl_pkg::*;

   localparam int     POINTS      = MAX_POINTS_DEFAULT;
   localparam int     ITEM_TARGET = 1050;
   localparam int     CYCLE_LIMIT = 1000000;
   localparam longint T_MIN       = -64'sd2147483648;
   localparam longint T_MAX       = 64'sd2147483647;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = CMD_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;

   int     error_count;
   int     outstanding;
   int     answers_checked;
   int     cycle_count;
   int     gap_pct   = 19;
   int     stall_pct = 86;
   int     loads_sent;
   int     queries_sent;
   int     settings_written;
   int     point_count_now;
   longint shadow_time[POINTS];

   piecewise_linear_profile_lookup_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pwl_lookup_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .outstanding     (outstanding),
      .answers_checked (answers_checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d answers outstanding.",
                  cycle_count, outstanding);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic longint rand_between(input longint lo, input longint hi);
      longint unsigned r;
      r = {$urandom, $urandom};
      return lo + longint'(r % longint'(hi - lo + 1));
   endfunction

   task automatic send_request(input logic cmd, input logic [REQ_DATA_W-1:0] data);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_point(input int idx, input longint t, input logic [ACCEL_W-1:0] a,
                             input logic [DUR_W-1:0] d);
      logic signed [TIME_W-1:0] tt;
      tt = t[TIME_W-1:0];
      shadow_time[idx] = longint'(tt);
      loads_sent++;
      send_request(CMD_LOAD, {4'b0, TIME_W'($urandom), d, a, tt, IDX_W'(idx)});
   endtask

   task automatic query_at(input longint q);
      queries_sent++;
      send_request(CMD_QUERY, {4'b0, q[TIME_W-1:0], DUR_W'($urandom), ACCEL_W'($urandom),
                               TIME_W'($urandom), IDX_W'($urandom)});
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_point_count(input int value);
      point_count_now = value;
      settings_written++;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic reload_table();
      longint vals[POINTS];
      int     order[$];
      longint t;
      longint step_max;
      if ($urandom_range(2) == 0) begin
         foreach (vals[i]) vals[i] = longint'($signed($urandom));
         vals.sort();
      end else begin
         case ($urandom_range(2))
            0: begin
               step_max = 3;
            end
            1: begin
               step_max = 2000;
            end
            default: begin
               step_max = 5000000;
            end
         endcase
         t = rand_between(T_MIN, T_MAX - 17 * step_max);
         foreach (vals[i]) begin
            t += rand_between(1, step_max);
            vals[i] = t;
         end
      end
      if ($urandom_range(4) == 0) begin
         vals[$urandom_range(POINTS - 1)] = vals[$urandom_range(POINTS - 1)];
      end
      for (int i = 0; i < POINTS; i++) order.push_back(i);
      order.shuffle();
      foreach (order[k]) begin
         load_point(order[k], vals[order[k]], ACCEL_W'($urandom), DUR_W'($urandom));
      end
   endtask

   function automatic longint pick_query_time();
      int     n;
      int     i;
      longint lo;
      longint hi;
      n = (point_count_now > POINTS) ? POINTS : point_count_now;
      if (n < 2 || $urandom_range(9) == 0) begin
         return rand_between(T_MIN, T_MAX);
      end
      i  = $urandom_range(n - 2);
      lo = shadow_time[i];
      hi = shadow_time[i+1];
      case ($urandom_range(5))
         0: begin
            return lo;
         end
         1: begin
            return hi;
         end
         2: begin
            return lo + 1;
         end
         3: begin
            return hi - 1;
         end
         4: begin
            return (lo < hi) ? rand_between(lo, hi) : rand_between(hi, lo);
         end
         default: begin
            if ($urandom_range(1) == 0) begin
               return shadow_time[0] - longint'($urandom_range(1000));
            end
            return shadow_time[n-1] + longint'($urandom_range(1000));
         end
      endcase
   endfunction

   initial begin
      int     setting;
      int     phase_len;
      int     idx;
      longint lo;
      longint hi;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_point_count(0);
      query_at(64'sd0);
      for (int i = 0; i < POINTS; i++) begin
         if (i == 0) begin
            load_point(i, T_MIN, 16'h8000, 16'h0000);
         end else if (i == POINTS - 1) begin
            load_point(i, T_MAX, 16'h7FFF, 16'hFFFF);
         end else begin
            load_point(i, longint'((i - 7) * 1000), 16'(i[0] ? -1200 * i : 1700 * i),
                       16'(4100 * i));
         end
      end
      settle();
      set_point_count(1);
      query_at(shadow_time[3]);
      settle();
      set_point_count(16);
      query_at(T_MIN);
      query_at(T_MAX);
      query_at(shadow_time[5]);
      query_at(shadow_time[5] + 317);
      query_at(shadow_time[14] + 1);
      query_at(shadow_time[0] + 1);
      query_at(shadow_time[15] - 1);
      settle();
      set_point_count(17);
      query_at(shadow_time[7] + 500);
      settle();
      set_point_count(31);
      query_at(shadow_time[9] - 1);

      while (loads_sent + queries_sent < ITEM_TARGET) begin
         if (loads_sent + queries_sent >= 2 * ITEM_TARGET / 3) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if (loads_sent + queries_sent >= ITEM_TARGET / 3) begin
            gap_pct   = 86;
            stall_pct = 19;
         end
         settle();
         case ($urandom_range(19))
            0: begin
               setting = 0;
            end
            1: begin
               setting = 1;
            end
            2, 3: begin
               setting = $urandom_range(2, 15);
            end
            4, 5: begin
               setting = $urandom_range(17, 31);
            end
            default: begin
               setting = 16;
            end
         endcase
         set_point_count(setting);
         if ($urandom_range(9) < 5) begin
            reload_table();
         end
         phase_len = $urandom_range(10, 40);
         repeat (phase_len) begin
            if ($urandom_range(4) == 0) begin
               idx = $urandom_range(POINTS - 1);
               lo  = (idx == 0) ? T_MIN : shadow_time[idx-1] + 1;
               hi  = (idx == POINTS - 1) ? T_MAX : shadow_time[idx+1] - 1;
               load_point(idx, (lo <= hi) ? rand_between(lo, hi) : rand_between(T_MIN, T_MAX),
                          ACCEL_W'($urandom), DUR_W'($urandom));
            end else begin
               query_at(pick_query_time());
            end
         end
      end
      settle();

      $display("Sent %0d point loads and %0d queries over %0d point-count settings.",
               loads_sent, queries_sent, settings_written);
      $display("Checked %0d answers under receiver stalls, sender gaps and full rate.",
               answers_checked);
      if (error_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
